// ===== rtl/atmf_pkg.sv =====
// ----------------------------------------------------------------------------
// atmf_pkg
// Shared types and constants of the alpha-trimmed mean filter.
// ----------------------------------------------------------------------------
package atmf_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_DW  = 32;
    localparam int CFG_AW  = 4;
    localparam int CFG_RW  = 11;
    localparam int RAD_RW  = 2;
    localparam int POS_W   = 10;
    localparam int IN_DW   = 8;
    localparam int OUT_DW  = 32;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // item kinds carried on the input tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_UP,
        S_READ,
        S_WAIT,
        S_PUSH,
        S_COMB,
        S_MUL,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/atmf_line_store.sv =====
// ----------------------------------------------------------------------------
// atmf_line_store
// Pixel ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module atmf_line_store #(
    parameter int DEPTH = 6151,
    parameter int AW    = 13
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [atmf_pkg::PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [atmf_pkg::PIX_W-1:0] o_rdata
);
    import atmf_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/atmf_col_cell.sv =====
// ----------------------------------------------------------------------------
// atmf_col_cell
// One window column summary (valid, sum, min, max); shifts to its neighbor.
// ----------------------------------------------------------------------------
module atmf_col_cell #(
    parameter int SUM_W = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_shift,
    input  logic                       i_vld,
    input  logic [SUM_W-1:0]           i_sum,
    input  logic [atmf_pkg::PIX_W-1:0] i_lo,
    input  logic [atmf_pkg::PIX_W-1:0] i_hi,
    output logic                       o_vld,
    output logic [SUM_W-1:0]           o_sum,
    output logic [atmf_pkg::PIX_W-1:0] o_lo,
    output logic [atmf_pkg::PIX_W-1:0] o_hi
);
    import atmf_pkg::*;

    logic             r_vld;
    logic [SUM_W-1:0] r_sum;
    logic [PIX_W-1:0] r_lo;
    logic [PIX_W-1:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sum <= i_sum;
            r_lo  <= i_lo;
            r_hi  <= i_hi;
        end
    end

    assign o_vld = r_vld;
    assign o_sum = r_sum;
    assign o_lo  = r_lo;
    assign o_hi  = r_hi;

endmodule

// ===== rtl/atmf_recip_div.sv =====
// ----------------------------------------------------------------------------
// atmf_recip_div
// Divide a window sum by a small count through a reciprocal table.
// ----------------------------------------------------------------------------
module atmf_recip_div #(
    parameter int SUM_W = 14,
    parameter int CNT_W = 6,
    parameter int SHIFT = 20
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [SUM_W-1:0]           i_sum,
    input  logic [CNT_W-1:0]           i_div,
    output logic [atmf_pkg::PIX_W-1:0] o_quot
);
    import atmf_pkg::*;

    localparam int NREC = 1 << CNT_W;

    logic [SHIFT-1:0]       w_recip [NREC];
    logic [SUM_W+SHIFT-1:0] r_prod;

    // ceil(2^SHIFT / d); exact for every sum below 2^SUM_W
    for (genvar d = 0; d < NREC; d++) begin : g_recip
        if (d < 2) begin : g_none
            assign w_recip[d] = '0;
        end else begin : g_val
            localparam longint RECIP = ((64'd1 << SHIFT) + d - 1) / d;
            assign w_recip[d] = SHIFT'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= (SUM_W+SHIFT)'(i_sum) * (SUM_W+SHIFT)'(w_recip[i_div]);
        end
    end

    assign o_quot = r_prod[SHIFT +: PIX_W];

endmodule

// ===== rtl/alpha_trimmed_mean_filter_top.sv =====
// ----------------------------------------------------------------------------
// alpha_trimmed_mean_filter_top
// Trim-one alpha-trimmed mean over a clipped square window of a raster image.
// ----------------------------------------------------------------------------
//  Channel   Dir  Transfer when            Content
//  s_axis    in   tvalid & tready          tdata = pixel_in, tuser = cmd
//  m_axis    out  tvalid & tready          tdata = pixel_out/out_row/out_col,
//                                          tlast = last_of_image
//  APB       in   psel&penable&pwrite      width, height, radius at 0x0/0x4/0x8
//
//  An item without a result ends at the check. One with a result loads
//  columns into the cell chain (one normally, R+1 at a row start), each by a
//  start, up steps (up <= R), a read per window row (rows <= 2R+1), a wait
//  and a push (start and push only past the right edge), then combines,
//  divides and emits. The line store's single read port sets the per-column
//  cost. No clearing pass after reset: the store is only read where written.
//  A stalled output holds in its register while the next item is taken; the
//  block waits only when a second result is ready before the first has left.
// ----------------------------------------------------------------------------
module alpha_trimmed_mean_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [atmf_pkg::IN_DW-1:0]  s_axis_tdata,  // [7:0] pixel_in
    input  logic                        s_axis_tuser,  // [0] cmd
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [atmf_pkg::OUT_DW-1:0] m_axis_tdata,  // [7:0] pixel_out,
                                                       // [17:8] out_row,
                                                       // [27:18] out_col
    output logic                        m_axis_tlast,  // last_of_image
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atmf_pkg::CFG_AW-1:0] paddr,
    input  logic [atmf_pkg::CFG_DW-1:0] pwdata,
    output logic [atmf_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import atmf_pkg::*;

    localparam int NCELL = 2 * MAX_RADIUS + 1;
    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int RW    = $clog2(NCELL + 1);
    localparam int CSW   = $clog2(NCELL * 255 + 1);
    localparam int SW    = $clog2(NCELL * NCELL * 255 + 1);
    localparam int CNTW  = $clog2(NCELL * NCELL + 1);
    localparam int KSH   = SW + CNTW;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int ROWW  = $clog2(MAX_HEIGHT);
    localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_A = (AW+1)'(DEPTH);

    // ---------------- configuration registers ----------------
    logic [CFG_RW-1:0] r_cfg_w;
    logic [CFG_RW-1:0] r_cfg_h;
    logic [RAD_RW-1:0] r_cfg_r;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_RW'(1024);
            r_cfg_h <= CFG_RW'(1024);
            r_cfg_r <= RAD_RW'(1);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_cfg_w <= pwdata[CFG_RW-1:0];
                REG_HEIGHT: r_cfg_h <= pwdata[CFG_RW-1:0];
                REG_RADIUS: r_cfg_r <= pwdata[RAD_RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = CFG_DW'(r_cfg_w);
            REG_HEIGHT: prdata = CFG_DW'(r_cfg_h);
            REG_RADIUS: prdata = CFG_DW'(r_cfg_r);
            default:    prdata = '0;
        endcase
    end

    // restart on a write to a known register
    logic w_cfg_restart;
    assign w_cfg_restart = w_cfg_wr && (paddr[3:2] == REG_WIDTH ||
                           paddr[3:2] == REG_HEIGHT || paddr[3:2] == REG_RADIUS);

    // clamp registers into their working ranges
    logic [WW-1:0]   w_w;
    logic [HW-1:0]   w_h;
    logic [RADW-1:0] w_r;

    always_comb begin
        if (int'(r_cfg_w) < 2)               w_w = WW'(2);
        else if (int'(r_cfg_w) > MAX_WIDTH)  w_w = WW'(MAX_WIDTH);
        else                                 w_w = WW'(r_cfg_w);
        if (int'(r_cfg_h) < 2)               w_h = HW'(2);
        else if (int'(r_cfg_h) > MAX_HEIGHT) w_h = HW'(MAX_HEIGHT);
        else                                 w_h = HW'(r_cfg_h);
        if (r_cfg_r == '0)                   w_r = RADW'(1);
        else if (int'(r_cfg_r) > MAX_RADIUS) w_r = RADW'(MAX_RADIUS);
        else                                 w_r = RADW'(r_cfg_r);
    end

    // pixel count of an image and lead of input over output
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_lag;

    always_ff @(posedge i_clk) begin
        r_total <= TW'(w_w * w_h);
        r_lag   <= TW'(w_r * w_w) + TW'(w_r) + TW'(1);
    end

    // ---------------- state ----------------
    t_state r_state;
    t_state n_state;

    logic [TW-1:0]   r_recv;
    logic [AW-1:0]   r_in_addr;
    logic [TW-1:0]   r_k;
    logic [AW-1:0]   r_k_addr;
    logic [ROWW-1:0] r_row;
    logic [COLW-1:0] r_col;

    logic [RADW-1:0] r_up_n;
    logic [RW-1:0]   r_rows;
    logic [RADW:0]   r_push_cnt;
    logic [RADW-1:0] r_dx;
    logic [RADW-1:0] r_up_cnt;
    logic [RW-1:0]   r_rd_cnt;
    logic [AW-1:0]   r_addr;
    logic            r_new_vld;
    logic            r_rd_vld;
    logic [CSW-1:0]  r_acc_sum;
    logic [PIX_W-1:0] r_acc_lo;
    logic [PIX_W-1:0] r_acc_hi;
    logic [SW-1:0]   r_tsum;
    logic [CNTW-1:0] r_div;

    logic            r_out_vld;
    logic [OUT_DW-1:0] r_out_data;
    logic            r_out_last;

    // ---------------- handshake decode ----------------
    logic w_in_acc;
    logic w_pix_wr;
    logic w_full;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_recv == r_total);
    assign w_pix_wr      = w_in_acc && (s_axis_tuser == CMD_PIXEL) && !w_full;

    // ---------------- emission test ----------------
    logic [TW:0] w_need;
    logic        w_ready;

    always_comb begin
        w_need = (TW+1)'(r_k) + (TW+1)'(r_lag);
        if (w_need > (TW+1)'(r_total)) begin
            w_need = (TW+1)'(r_total);
        end
        w_ready = (r_k < r_total) && ((TW+1)'(r_recv) >= w_need);
    end

    // rows of the clipped window
    logic [RADW-1:0] w_up;
    logic [RADW-1:0] w_down;

    always_comb begin
        int below;
        below = int'(w_h) - 1 - int'(r_row);
        if (int'(r_row) >= int'(w_r)) w_up = w_r;
        else                          w_up = RADW'(r_row);
        if (below >= int'(w_r))       w_down = w_r;
        else                          w_down = RADW'(below);
    end

    // ---------------- address helpers ----------------
    logic [AW:0] w_w_a;
    logic [AW:0] w_col_start;
    logic [AW:0] w_addr_up;
    logic [AW:0] w_addr_dn;
    logic [AW:0] w_in_next;
    logic [AW:0] w_k_next;
    logic [WW:0] w_x;

    assign w_w_a = (AW+1)'(w_w);

    always_comb begin
        w_col_start = (AW+1)'(r_k_addr) + (AW+1)'(r_dx);
        if (w_col_start >= DEPTH_A) w_col_start = w_col_start - DEPTH_A;
        if ((AW+1)'(r_addr) >= w_w_a) w_addr_up = (AW+1)'(r_addr) - w_w_a;
        else                          w_addr_up = (AW+1)'(r_addr) + DEPTH_A - w_w_a;
        w_addr_dn = (AW+1)'(r_addr) + w_w_a;
        if (w_addr_dn >= DEPTH_A) w_addr_dn = w_addr_dn - DEPTH_A;
        w_in_next = (AW+1)'(r_in_addr) + (AW+1)'(1);
        if (w_in_next >= DEPTH_A) w_in_next = '0;
        w_k_next = (AW+1)'(r_k_addr) + (AW+1)'(1);
        if (w_k_next >= DEPTH_A) w_k_next = '0;
        w_x = (WW+1)'(r_col) + (WW+1)'(r_dx);
    end

    // ---------------- line store ----------------
    logic [PIX_W-1:0] w_rdata;

    atmf_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_pix_wr),
        .i_waddr (r_in_addr),
        .i_wdata (s_axis_tdata[PIX_W-1:0]),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // ---------------- column cell chain ----------------
    // highest cell holds the newest column, col + R
    logic             c_vld [NCELL+1];
    logic [CSW-1:0]   c_sum [NCELL+1];
    logic [PIX_W-1:0] c_lo  [NCELL+1];
    logic [PIX_W-1:0] c_hi  [NCELL+1];
    logic             w_clear;
    logic             w_shift;

    assign w_clear = (r_state == S_CHECK) && w_ready && (r_col == '0);
    assign w_shift = (r_state == S_PUSH);

    assign c_vld[NCELL] = r_new_vld;
    assign c_sum[NCELL] = r_acc_sum;
    assign c_lo[NCELL]  = r_acc_lo;
    assign c_hi[NCELL]  = r_acc_hi;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        atmf_col_cell #(
            .SUM_W (CSW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_shift (w_shift),
            .i_vld   (c_vld[i+1]),
            .i_sum   (c_sum[i+1]),
            .i_lo    (c_lo[i+1]),
            .i_hi    (c_hi[i+1]),
            .o_vld   (c_vld[i]),
            .o_sum   (c_sum[i]),
            .o_lo    (c_lo[i]),
            .o_hi    (c_hi[i])
        );
    end

    // combine the window columns
    logic [SW-1:0]    w_sum;
    logic [PIX_W-1:0] w_lo;
    logic [PIX_W-1:0] w_hi;
    logic [RW-1:0]    w_ncols;
    logic [CNTW-1:0]  w_count;

    always_comb begin
        w_sum   = '0;
        w_lo    = PIX_MAX;
        w_hi    = '0;
        w_ncols = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (i >= NCELL - 1 - 2 * int'(w_r) && c_vld[i]) begin
                w_sum   = w_sum + SW'(c_sum[i]);
                w_ncols = w_ncols + RW'(1);
                if (c_lo[i] < w_lo) w_lo = c_lo[i];
                if (c_hi[i] > w_hi) w_hi = c_hi[i];
            end
        end
        w_count = CNTW'(w_ncols) * CNTW'(r_rows);
    end

    // ---------------- divider ----------------
    logic [PIX_W-1:0] w_quot;

    atmf_recip_div #(
        .SUM_W (SW),
        .CNT_W (CNTW),
        .SHIFT (KSH)
    ) u_div (
        .i_clk  (i_clk),
        .i_load (r_state == S_MUL),
        .i_sum  (r_tsum),
        .i_div  (r_div),
        .o_quot (w_quot)
    );

    // ---------------- sequencer ----------------
    logic w_emit;
    logic w_last;

    assign w_last = (r_k == r_total - TW'(1));
    assign w_emit = (r_state == S_EMIT) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_CHECK;
            S_CHECK: n_state = w_ready ? S_START : S_IDLE;
            S_START: begin
                if (w_x >= (WW+1)'(w_w)) n_state = S_PUSH;
                else if (r_up_n != '0)   n_state = S_UP;
                else                     n_state = S_READ;
            end
            S_UP:    if (r_up_cnt == RADW'(1)) n_state = S_READ;
            S_READ:  if (r_rd_cnt == RW'(1))   n_state = S_WAIT;
            S_WAIT:  n_state = S_PUSH;
            S_PUSH:  n_state = (r_push_cnt == (RADW+1)'(1)) ? S_COMB : S_START;
            S_COMB:  n_state = S_MUL;
            S_MUL:   n_state = S_EMIT;
            S_EMIT:  if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_restart) begin
            r_recv    <= '0;
            r_in_addr <= '0;
            r_k       <= '0;
            r_k_addr  <= '0;
            r_row     <= '0;
            r_col     <= '0;
        end else begin
            if (w_pix_wr) begin
                r_recv    <= r_recv + TW'(1);
                r_in_addr <= w_in_next[AW-1:0];
            end
            if (w_emit) begin
                if (w_last) begin
                    r_recv    <= '0;
                    r_in_addr <= '0;
                    r_k       <= '0;
                    r_k_addr  <= '0;
                    r_row     <= '0;
                    r_col     <= '0;
                end else begin
                    r_k      <= r_k + TW'(1);
                    r_k_addr <= w_k_next[AW-1:0];
                    if ((WW+1)'(r_col) + (WW+1)'(1) >= (WW+1)'(w_w)) begin
                        r_col <= '0;
                        r_row <= r_row + ROWW'(1);
                    end else begin
                        r_col <= r_col + COLW'(1);
                    end
                end
            end
        end
    end

    // column gathering
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CHECK: begin
                r_up_n <= w_up;
                r_rows <= RW'(w_up) + RW'(w_down) + RW'(1);
                if (r_col == '0) begin
                    r_dx       <= '0;
                    r_push_cnt <= (RADW+1)'(w_r) + (RADW+1)'(1);
                end else begin
                    r_dx       <= w_r;
                    r_push_cnt <= (RADW+1)'(1);
                end
            end
            S_START: begin
                r_addr    <= w_col_start[AW-1:0];
                r_up_cnt  <= r_up_n;
                r_rd_cnt  <= r_rows;
                r_new_vld <= (w_x < (WW+1)'(w_w));
            end
            S_UP: begin
                r_addr   <= w_addr_up[AW-1:0];
                r_up_cnt <= r_up_cnt - RADW'(1);
            end
            S_READ: begin
                r_addr   <= w_addr_dn[AW-1:0];
                r_rd_cnt <= r_rd_cnt - RW'(1);
            end
            S_PUSH: begin
                r_dx       <= r_dx + RADW'(1);
                r_push_cnt <= r_push_cnt - (RADW+1)'(1);
            end
            S_COMB: begin
                r_tsum <= w_sum - SW'(w_lo) - SW'(w_hi);
                r_div  <= w_count - CNTW'(2);
            end
            default: ;
        endcase
    end

    // accumulate the column as read data returns
    always_ff @(posedge i_clk) begin
        if (r_state == S_START) begin
            r_acc_sum <= '0;
            r_acc_lo  <= PIX_MAX;
            r_acc_hi  <= '0;
        end else if (r_rd_vld) begin
            r_acc_sum <= r_acc_sum + CSW'(w_rdata);
            if (w_rdata < r_acc_lo) r_acc_lo <= w_rdata;
            if (w_rdata > r_acc_hi) r_acc_hi <= w_rdata;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {(OUT_DW - PIX_W - 2 * POS_W)'(0),
                           POS_W'(r_col), POS_W'(r_row), w_quot};
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== tb/tb_alpha_trimmed_mean_filter_top.sv =====
// ----------------------------------------------------------------------------
// tb_alpha_trimmed_mean_filter_top
// Self-checking bench for the trim-one alpha-trimmed mean filter: a directed
// table of short images is followed by random images. Each transfer is
// predicted and compared in order against the result stream.
// ----------------------------------------------------------------------------
module tb_alpha_trimmed_mean_filter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import atmf_pkg::*;

    localparam int MAXW  = 1024;
    localparam int MAXH  = 1024;
    localparam int MAXR  = 3;
    localparam int DEPTH = 2 * MAXR * MAXW + 2 * MAXR + 1;

    typedef struct packed {
        logic [7:0] pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } mean_t;

    typedef struct {
        logic       cmd;
        logic [7:0] pix;
    } item_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = CMD_PIXEL;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    always #1 i_clk = ~i_clk;

    alpha_trimmed_mean_filter_top i_dut (.*);

    // predictor state
    logic [7:0]  pix_ring[DEPTH];
    int unsigned cfg_w = 1024, cfg_h = 1024, cfg_r = 1;
    int unsigned in_row, in_col, out_row, out_col;
    bit          img_full;
    mean_t       pending_means[$];
    int          n_fail = 0;
    bit          hold_rx = 0;     // receiver hold-off request
    bit          rx_quiet = 0;    // no random stalls on the receiver

    function automatic int unsigned clampv(int unsigned v, int unsigned lo,
                                           int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void restart_counts();
        in_row = 0; in_col = 0; out_row = 0; out_col = 0; img_full = 0;
    endfunction

    function automatic logic [7:0] trimmed_mean(int unsigned row, int unsigned col,
                                                int unsigned w, int unsigned h,
                                                int unsigned r);
        int unsigned r0, r1, c0, c1, sum, cnt, lo, hi, v;
        r0 = row >= r ? row - r : 0;
        r1 = row + r < h ? row + r : h - 1;
        c0 = col >= r ? col - r : 0;
        c1 = col + r < w ? col + r : w - 1;
        sum = 0; cnt = 0; lo = 255; hi = 0;
        for (int unsigned y = r0; y <= r1; y++)
            for (int unsigned x = c0; x <= c1; x++) begin
                v = pix_ring[(y * w + x) % DEPTH];
                sum += v; cnt++;
                if (v < lo) lo = v;
                if (v > hi) hi = v;
            end
        return 8'((sum - lo - hi) / (cnt - 2));
    endfunction

    // advance the predictor by one accepted item
    function automatic void filter_item(item_t it);
        int unsigned w, h, r, total, got, k, need;
        mean_t m;
        w = clampv(cfg_w, 2, MAXW);
        h = clampv(cfg_h, 2, MAXH);
        r = clampv(cfg_r, 1, MAXR);
        total = w * h;
        if (it.cmd == CMD_PIXEL && !img_full) begin
            pix_ring[(in_row * w + in_col) % DEPTH] = it.pix;
            if (++in_col >= w) begin
                in_col = 0;
                if (++in_row >= h) begin
                    in_row = 0; img_full = 1;
                end
            end
        end
        got = img_full ? total : in_row * w + in_col;
        k = out_row * w + out_col;
        need = k + r * w + r + 1;
        if (need > total) need = total;
        if (k >= total || got < need) return;
        m.pix = trimmed_mean(out_row, out_col, w, h, r);
        m.row = 10'(out_row);
        m.col = 10'(out_col);
        m.last = (k == total - 1);
        pending_means.push_back(m);
        if (m.last) restart_counts();
        else if (++out_col >= w) begin
            out_col = 0; out_row++;
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off on request, field compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        mean_t exp_m;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_means.size() == 0) begin
                    $error("unexpected result tdata=%h", m_axis_tdata);
                    n_fail++;
                end else begin
                    exp_m = pending_means.pop_front();
                    if (m_axis_tdata[7:0] !== exp_m.pix) begin
                        $error("pixel_out exp %0d got %0d", exp_m.pix, m_axis_tdata[7:0]);
                        n_fail++;
                    end
                    if (m_axis_tdata[17:8] !== exp_m.row) begin
                        $error("out_row exp %0d got %0d", exp_m.row, m_axis_tdata[17:8]);
                        n_fail++;
                    end
                    if (m_axis_tdata[27:18] !== exp_m.col) begin
                        $error("out_col exp %0d got %0d", exp_m.col, m_axis_tdata[27:18]);
                        n_fail++;
                    end
                    if (m_axis_tlast !== exp_m.last) begin
                        $error("last_of_image exp %0d got %0d", exp_m.last, m_axis_tlast);
                        n_fail++;
                    end
                end
            end
            m_axis_tready <= !hold_rx && (rx_quiet || $urandom_range(99) >= 18);
        end
    end

    // ------------------------------------------------------------------
    // drive helpers
    // ------------------------------------------------------------------
    bit tx_quiet = 0;

    // offer one item and hold it until the transfer
    task automatic send_item(item_t it);
        while (!tx_quiet && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= it.pix;
        do @(posedge i_clk); while (!s_axis_tready);
        filter_item(it);
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait out every expected result, then let the pipeline tail pass
    task automatic wait_drained();
        drop_valid();
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_AW'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = val & 32'h7FF;
            REG_HEIGHT: cfg_h = val & 32'h7FF;
            default:    cfg_r = val & 32'h3;
        endcase
        restart_counts();
    endtask

    task automatic set_shape(int unsigned w, int unsigned h, int unsigned r);
        wait_drained();
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_RADIUS, r);
    endtask

    // one image of random pixels, then ndrain trailing items, mostly drains
    task automatic send_image(int unsigned npix, int unsigned ndrain, bit noisy);
        item_t it;
        for (int unsigned i = 0; i < npix; i++) begin
            it.cmd = CMD_PIXEL;
            it.pix = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                              : 8'($urandom);
            if (noisy && $urandom_range(19) == 0) it.cmd = CMD_DRAIN;
            send_item(it);
        end
        for (int unsigned i = 0; i < ndrain; i++) begin
            it.cmd = $urandom_range(3) ? CMD_DRAIN : CMD_PIXEL;
            it.pix = 8'($urandom);
            send_item(it);
        end
    endtask

    // directed rows: {cmd, pixel}; 2x2 image, radius 1, every window holds all
    // four pixels, so the mean of the two middle values is easy to read off
    item_t dir_rows[] = '{
        '{CMD_DRAIN, 8'h00},   // drain with nothing ready
        '{CMD_PIXEL, 8'h00}, '{CMD_PIXEL, 8'hFF},
        '{CMD_PIXEL, 8'h10}, '{CMD_PIXEL, 8'h20},
        '{CMD_PIXEL, 8'hAA},   // pixel after the last pixel acts as a drain
        '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00},
        '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'hFF},
        '{CMD_PIXEL, 8'hFF}, '{CMD_PIXEL, 8'hFF},
        '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00}, '{CMD_DRAIN, 8'h00},
        '{CMD_DRAIN, 8'h00}
    };
    // expected pixel_out for the two images above: (0x10+0x20)/2 = 0x18
    logic [7:0] dir_means[8] = '{8'h18, 8'h18, 8'h18, 8'h18,
                                 8'hFF, 8'hFF, 8'hFF, 8'hFF};

    initial begin
        int unsigned w, h, r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shape is 1024x1024: stream past the first row until a few
        // results leave, then restart via config
        send_image(1030, 0, 0);
        set_shape(2, 2, 1);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        wait_drained();

        // out-of-range values clamp to the limits
        set_shape(0, 1, 0);          // used as 2x2, radius 1
        send_image(4, 2, 0);
        set_shape(3, 11'h7FF, 3);    // used as 3x1024, radius 3, partial image
        send_image(60, 0, 0);

        // receiver hold-off while the sender keeps offering
        set_shape(5, 4, 2);
        hold_rx = 1;
        fork
            send_image(20, 15, 0);
            begin repeat (300) @(posedge i_clk); hold_rx = 0; end
        join

        // random small images
        for (int n = 0; n < 14; n++) begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 8);
            r = $urandom_range(1, 3);
            set_shape(w, h, r);
            tx_quiet = (n >= 4 && n < 7);
            rx_quiet = tx_quiet;
            send_image(w * h, $urandom_range(2) ? w * r + r + 3 : 2, n % 4 == 3);
        end
        wait_drained();
        if (n_fail == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // directed means: the table's results must match the read-off values
    int dir_idx = 0;
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && cfg_w == 2 && cfg_h == 2
            && cfg_r == 1 && dir_idx < 8) begin
            if (m_axis_tdata[7:0] !== dir_means[dir_idx]) begin
                $error("pixel_out exp %0d got %0d", dir_means[dir_idx],
                       m_axis_tdata[7:0]);
                n_fail++;
            end
            dir_idx <= dir_idx + 1;
        end
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/atmf_pkg.sv
rtl/atmf_line_store.sv
rtl/atmf_col_cell.sv
rtl/atmf_recip_div.sv
rtl/alpha_trimmed_mean_filter_top.sv
tb/tb_alpha_trimmed_mean_filter_top.sv
